// ===== sv/sppf_pkg.sv =====
package sppf_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    localparam int BUSY_W = 32;
    localparam int MHZ_W  = 13;
    localparam int WORK_W = BUSY_W + MHZ_W;
    localparam int PROD_W = WORK_W + MHZ_W;
    localparam int LO_W   = 23;
    localparam int HI_W   = WORK_W - LO_W;
    localparam int ENTRY_W = WORK_W + 1;

    localparam int DIV_STEPS = MHZ_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [MHZ_W-1:0] CEIL_RESET  = MHZ_W'(4800);
    localparam logic [MHZ_W-1:0] FLOOR_RESET = '0;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 1'b1;

endpackage

// ===== sv/sppf_ram.sv =====
module sppf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/slack_proportional_freq_planner.sv =====
// Slack-proportional frequency planner. Send one request per thread slot with its busy time,
// the frequency it last ran at and a history flag; final_slot closes the set (a set that
// reaches 64 slots closes by itself). Each request passes through capture, a 32x13 multiply
// for work, then the store write and peak update. After the closing request the block
// returns one target per slot in slot order, the last one flagged by final_target. A slot
// with history takes a read of the work store, a 13x45 product formed from two partial
// products, then 13 steps of the shared restoring divider against the peak work. A slot
// without history, or any slot of a set whose peak is zero, gets the ceiling with no
// product or division. No new request is taken until the last target of the set has gone
// out. Write ceiling and floor only while the block is idle.
module slack_proportional_freq_planner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [sppf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sppf_pkg::MHZ_W-1:0]      i_cfg_data,
    // request channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [sppf_pkg::BUSY_W-1:0]     i_busy_time_us,
    input  logic [sppf_pkg::MHZ_W-1:0]      i_prior_mhz,
    input  logic                            i_has_history,
    input  logic                            i_final_slot,
    // target channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [sppf_pkg::MHZ_W-1:0]      o_planned_mhz,
    output logic                            o_final_target
);

    import sppf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,  // waiting for a request
        S_LOAD  = 7'b0000010,  // work = busy * freq
        S_STORE = 7'b0000100,  // store write, peak update
        S_READ  = 7'b0001000,  // issue store read for the slot being planned
        S_MULLO = 7'b0010000,  // low partial product, or short path to ceiling
        S_MULHI = 7'b0100000,  // high partial product, divider load
        S_DIV   = 7'b1000000   // one quotient bit per cycle
    } t_state;

    // config registers
    logic [MHZ_W-1:0]  r_ceiling;
    logic [MHZ_W-1:0]  r_floor;

    // control
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_slot_count, n_slot_count;
    logic [CNT_W-1:0]  r_emit_idx, n_emit_idx;
    logic [WORK_W-1:0] r_peak, n_peak;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    // payload
    logic [BUSY_W-1:0]        r_busy;
    logic [MHZ_W-1:0]         r_freq;
    logic                     r_hist;
    logic                     r_fin;
    logic [WORK_W-1:0]        r_work;
    logic [MHZ_W+LO_W-1:0]    r_acc;
    logic [HI_W-1:0]          r_whi;
    logic [WORK_W-1:0]        r_rem;
    logic [MHZ_W-1:0]         r_nlo;
    logic [MHZ_W-1:0]         r_quo;
    logic [MHZ_W-1:0]         r_target;
    logic                     r_final;

    // store port signals
    logic               ram_we;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               accept_in;
    logic               accept_out;
    logic [CNT_W-1:0]   count_inc;
    logic               emit_last;

    logic [MHZ_W+HI_W-1:0] mul_hi;
    logic [PROD_W-1:0]  prod;
    logic [WORK_W:0]    trial;
    logic               q_bit;
    logic [WORK_W:0]    diff;
    logic [MHZ_W-1:0]   quo_next;
    logic [MHZ_W-1:0]   clamped;

    assign o_stall   = (r_state != S_IDLE) || r_out_valid;
    assign accept_in  = i_valid && !o_stall;
    assign accept_out = r_out_valid && !i_stall;
    assign count_inc  = r_slot_count + CNT_W'(1);
    assign emit_last  = (r_emit_idx + CNT_W'(1)) == r_slot_count;

    assign ram_wdata = {r_hist, r_work};

    // product of ceiling and work from the two partial products
    assign mul_hi = r_ceiling * r_whi;
    assign prod   = PROD_W'(r_acc) + (PROD_W'(mul_hi) << LO_W);

    // one restoring division step, remainder always below the peak
    assign trial    = {r_rem, r_nlo[MHZ_W-1]};
    assign q_bit    = trial >= {1'b0, r_peak};
    assign diff     = trial - {1'b0, r_peak};
    assign quo_next = {r_quo[MHZ_W-2:0], q_bit};

    // floor first, so the ceiling wins when floor exceeds it
    always_comb begin
        clamped = quo_next;
        if (clamped < r_floor) begin
            clamped = r_floor;
        end
        if (clamped > r_ceiling) begin
            clamped = r_ceiling;
        end
    end

    sppf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_work_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot_count[IDX_W-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_emit_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ram_we = (r_state == S_STORE);
    assign ram_re = (r_state == S_READ);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_slot_count = r_slot_count;
        n_emit_idx   = r_emit_idx;
        n_peak       = r_peak;
        n_step       = r_step;
        n_out_valid  = r_out_valid;

        if (accept_out) begin
            n_out_valid = 1'b0;
            if (emit_last) begin
                // set done, start a fresh one
                n_slot_count = '0;
                n_peak       = '0;
                n_state      = S_IDLE;
            end else begin
                n_emit_idx = r_emit_idx + CNT_W'(1);
                n_state    = S_READ;
            end
        end else if (!r_out_valid) begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept_in) begin
                        n_state = S_LOAD;
                    end
                end
                S_LOAD: begin
                    n_state = S_STORE;
                end
                S_STORE: begin
                    if (r_hist && (r_work > r_peak)) begin
                        n_peak = r_work;
                    end
                    n_slot_count = count_inc;
                    if (r_fin || (count_inc == CNT_W'(MAX_SLOTS))) begin
                        n_emit_idx = '0;
                        n_state    = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
                S_READ: begin
                    n_state = S_MULLO;
                end
                S_MULLO: begin
                    if (!ram_rdata[WORK_W] || (r_peak == '0)) begin
                        // no history or no peak: straight to the ceiling
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_MULHI;
                    end
                end
                S_MULHI: begin
                    n_step  = '0;
                    n_state = S_DIV;
                end
                S_DIV: begin
                    n_step = r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_count <= '0;
            r_emit_idx   <= '0;
            r_peak       <= '0;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
            r_ceiling    <= CEIL_RESET;
            r_floor      <= FLOOR_RESET;
        end else begin
            r_state      <= n_state;
            r_slot_count <= n_slot_count;
            r_emit_idx   <= n_emit_idx;
            r_peak       <= n_peak;
            r_step       <= n_step;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CEILING: r_ceiling <= i_cfg_data;
                    CFG_FLOOR:   r_floor   <= i_cfg_data;
                    default:     r_floor   <= r_floor;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_busy <= i_busy_time_us;
            // prior of zero stands for the ceiling at load time
            r_freq <= (i_prior_mhz != '0) ? i_prior_mhz : r_ceiling;
            r_hist <= i_has_history;
            r_fin  <= i_final_slot;
        end
        if (r_state == S_LOAD) begin
            r_work <= r_busy * r_freq;
        end
        if ((r_state == S_MULLO) && !r_out_valid) begin
            r_acc <= r_ceiling * ram_rdata[LO_W-1:0];
            r_whi <= ram_rdata[WORK_W-1:LO_W];
            r_target <= r_ceiling;
            r_final  <= emit_last;
        end
        if ((r_state == S_MULHI) && !r_out_valid) begin
            r_rem <= prod[PROD_W-1:MHZ_W];
            r_nlo <= prod[MHZ_W-1:0];
            r_quo <= '0;
        end
        if ((r_state == S_DIV) && !r_out_valid) begin
            r_rem <= q_bit ? diff[WORK_W-1:0] : trial[WORK_W-1:0];
            r_nlo <= {r_nlo[MHZ_W-2:0], 1'b0};
            r_quo <= quo_next;
            if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                r_target <= clamped;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_planned_mhz  = r_target;
    assign o_final_target = r_final;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot_count <= CNT_W'(MAX_SLOTS))
        else $error("slot count beyond set size");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_emit_idx < r_slot_count))
        else $error("planning a slot that was never loaded");

    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken while a target is pending");

    a_set_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_final_target) |=> (r_slot_count == '0 && r_peak == '0))
        else $error("set state not cleared after last target");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULHI && !r_out_valid) |=> (r_state == S_DIV && r_step == '0))
        else $error("divider did not start after product");
`endif

endmodule

// ===== tb/tb_slack_proportional_freq_planner.sv =====
`timescale 1ns / 100ps

module tb_slack_proportional_freq_planner;
    import sppf_pkg::*;

    // cycles allowed after the last target before the block counts as idle
    localparam int SETTLE_CYCLES  = 10;
    // long receiver hold-off used to back the block up into its input
    localparam int HOLD_CYCLES    = 400;
    // cycles without any accepted request or target before the run is abandoned
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum logic [2:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH,
        IDLE_HOLD
    } t_idle_mode;

    typedef struct packed {
        logic [BUSY_W-1:0] busy_us;
        logic [MHZ_W-1:0]  prior_mhz;
        logic              has_history;
        logic              final_slot;
    } t_slot_req;

    typedef struct packed {
        logic [MHZ_W-1:0] planned_mhz;
        logic             final_target;
    } t_target;

    // dut ports
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = CFG_CEILING;
    logic [MHZ_W-1:0]     i_cfg_data     = '0;
    logic                 i_valid        = 1'b0;
    logic                 o_stall;
    logic [BUSY_W-1:0]    i_busy_time_us = '0;
    logic [MHZ_W-1:0]     i_prior_mhz    = '0;
    logic                 i_has_history  = 1'b0;
    logic                 i_final_slot   = 1'b0;
    logic                 o_valid;
    logic                 i_stall        = 1'b0;
    logic [MHZ_W-1:0]     o_planned_mhz;
    logic                 o_final_target;

    // pending slot requests and targets still owed by the block
    t_slot_req slot_q[$];
    t_target   planned_q[$];

    // shadow of the planner: register copies and the set being collected
    logic [MHZ_W-1:0]  ceil_mhz  = CEIL_RESET;
    logic [MHZ_W-1:0]  floor_mhz = FLOOR_RESET;
    logic [WORK_W-1:0] work_store[MAX_SLOTS];
    logic              hist_marks[MAX_SLOTS];
    logic [WORK_W-1:0] peak_work  = '0;
    int                fill_count = 0;

    t_idle_mode idle_mode = IDLE_NONE;
    int         hold_count = 0;
    int         idle_cycles = 0;

    // run statistics
    int err_count       = 0;
    int slots_accepted  = 0;
    int sets_closed     = 0;
    int overflow_sets   = 0;
    int targets_checked = 0;
    int settings_used   = 0;

    slack_proportional_freq_planner dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_busy_time_us (i_busy_time_us),
        .i_prior_mhz    (i_prior_mhz),
        .i_has_history  (i_has_history),
        .i_final_slot   (i_final_slot),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_planned_mhz  (o_planned_mhz),
        .o_final_target (o_final_target)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // planner shadow
    // ------------------------------------------------------------------

    // target of one stored slot, using the registers as they stand at close
    function automatic logic [MHZ_W-1:0] scaled_target(input int slot);
        logic [PROD_W-1:0] quot;
        if (!hist_marks[slot] || peak_work == '0)
            return ceil_mhz;
        quot = (PROD_W'(ceil_mhz) * PROD_W'(work_store[slot])) / PROD_W'(peak_work);
        // floor first, so the ceiling wins when floor is above it
        if (quot < PROD_W'(floor_mhz))
            quot = PROD_W'(floor_mhz);
        if (quot > PROD_W'(ceil_mhz))
            quot = PROD_W'(ceil_mhz);
        return quot[MHZ_W-1:0];
    endfunction

    // store one accepted slot; on set close, queue a target for every slot
    task automatic absorb_slot(input t_slot_req req);
        logic [MHZ_W-1:0]  freq;
        logic [WORK_W-1:0] work;
        t_target           tgt;
        int                n;
        // prior of zero stands for the ceiling as it is at load time
        freq = (req.prior_mhz != '0) ? req.prior_mhz : ceil_mhz;
        work = WORK_W'(req.busy_us) * WORK_W'(freq);
        work_store[fill_count] = work;
        hist_marks[fill_count] = req.has_history;
        // only slots with history take part in the peak
        if (req.has_history && work > peak_work)
            peak_work = work;
        fill_count++;
        if (req.final_slot || fill_count == MAX_SLOTS) begin
            if (!req.final_slot)
                overflow_sets++;
            n = fill_count;
            for (int i = 0; i < n; i++) begin
                tgt.planned_mhz  = scaled_target(i);
                tgt.final_target = (i == n - 1);
                planned_q.insert(planned_q.size(), tgt);
            end
            sets_closed++;
            fill_count = 0;
            peak_work  = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // idling per phase
    // ------------------------------------------------------------------

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_SEND: return 70;
            IDLE_BOTH: return 15;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (idle_mode)
            IDLE_RECV: return 70;
            IDLE_BOTH: return 15;
            default:   return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request driver: pops the slot queue, predicts on every acceptance
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : slot_driver
        t_slot_req nxt;
        t_slot_req taken;
        logic      offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                taken.busy_us     = i_busy_time_us;
                taken.prior_mhz   = i_prior_mhz;
                taken.has_history = i_has_history;
                taken.final_slot  = i_final_slot;
                absorb_slot(taken);
                slots_accepted++;
            end
            // decide the next request without looking at stall
            offer = (slot_q.size() != 0) && ($urandom_range(99) >= send_idle_pct());
            if (offer) begin
                nxt = slot_q.pop_front();
                i_busy_time_us <= nxt.busy_us;
                i_prior_mhz    <= nxt.prior_mhz;
                i_has_history  <= nxt.has_history;
                i_final_slot   <= nxt.final_slot;
            end
            i_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // target monitor: checks against the oldest planned target, drives stall
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : target_monitor
        t_target want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                targets_checked++;
                if (planned_q.size() == 0) begin
                    $error("target with nothing planned: planned_mhz %0d final_target %0d",
                           o_planned_mhz, o_final_target);
                    err_count++;
                end else begin
                    want = planned_q.pop_front();
                    if (o_planned_mhz !== want.planned_mhz) begin
                        $error("planned_mhz: expected %0d, got %0d",
                               want.planned_mhz, o_planned_mhz);
                        err_count++;
                    end
                    if (o_final_target !== want.final_target) begin
                        $error("final_target: expected %0d, got %0d",
                               want.final_target, o_final_target);
                        err_count++;
                    end
                end
            end
            // long hold-off at the start of the pressure phase, counted here
            if (idle_mode == IDLE_HOLD && hold_count < HOLD_CYCLES) begin
                i_stall <= 1'b1;
                hold_count++;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct());
            end
            if (idle_mode != IDLE_HOLD)
                hold_count = 0;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: cycles in which neither channel moves anything
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or target moved for %0d cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_slot(input logic [BUSY_W-1:0] busy, input logic [MHZ_W-1:0] prior,
                              input logic hist, input logic fin);
        t_slot_req req;
        req.busy_us     = busy;
        req.prior_mhz   = prior;
        req.has_history = hist;
        req.final_slot  = fin;
        slot_q.insert(slot_q.size(), req);
    endtask

    function automatic logic [BUSY_W-1:0] rand_busy();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return BUSY_W'($urandom_range(1, 1000));
            default: return BUSY_W'($urandom);
        endcase
    endfunction

    function automatic logic [MHZ_W-1:0] rand_prior();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return MHZ_W'($urandom_range(1, 10));
            default: return MHZ_W'($urandom_range(0, 8191));
        endcase
    endfunction

    // one set of random slots; close marks the last one final
    task automatic queue_set(input int len, input logic close);
        logic idle_set;
        // now and then a whole set with no busy time, so the peak stays zero
        idle_set = ($urandom_range(7) == 0);
        for (int i = 0; i < len; i++)
            queue_slot(idle_set ? '0 : rand_busy(), rand_prior(),
                       ($urandom_range(7) != 0), (i == len - 1) ? close : 1'b0);
    endtask

    task automatic queue_random_sets(input int n_items);
        int added;
        int len;
        added = 0;
        while (added < n_items) begin
            len = $urandom_range(1, 12);
            queue_set(len, 1'b1);
            added += len;
        end
    endtask

    // write both registers while the block is idle, then update the shadow
    task automatic program_regs(input logic [MHZ_W-1:0] ceil, input logic [MHZ_W-1:0] flr);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CEILING;
        i_cfg_data <= ceil;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_FLOOR;
        i_cfg_data <= flr;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        ceil_mhz  = ceil;
        floor_mhz = flr;
        settings_used++;
        @(negedge i_clk);
    endtask

    task automatic program_random();
        logic [MHZ_W-1:0] ceil;
        logic [MHZ_W-1:0] flr;
        ceil = MHZ_W'($urandom_range(0, 8191));
        // mostly a floor under the ceiling, sometimes anywhere
        flr  = ($urandom_range(1) == 0) ? MHZ_W'($urandom_range(0, ceil))
                                         : MHZ_W'($urandom_range(0, 8191));
        program_regs(ceil, flr);
    endtask

    // all requests in, all targets out, then let the intake pipeline settle
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (slot_q.size() != 0 || i_valid || planned_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // registers at reset values: field extremes, prior of zero, no history
        idle_mode = IDLE_NONE;
        queue_slot('1, 13'd8191, 1'b1, 1'b0);
        queue_slot('0, 13'd0, 1'b1, 1'b0);
        queue_slot(32'd1, 13'd1, 1'b0, 1'b0);
        queue_slot(32'd12345, 13'd0, 1'b1, 1'b1);
        // single slot without history
        queue_slot(32'd500, 13'd2000, 1'b0, 1'b1);
        // zero peak: every slot gets the ceiling
        queue_slot('0, 13'd300, 1'b1, 1'b0);
        queue_slot('0, 13'd0, 1'b1, 1'b1);
        // large work on a slot without history stays out of the peak
        queue_slot(32'd4000000, 13'd8191, 1'b0, 1'b0);
        queue_slot(32'd20, 13'd100, 1'b1, 1'b0);
        queue_slot(32'd80, 13'd100, 1'b1, 1'b1);
        // open a set whose prior of zero is taken at the old ceiling
        queue_slot(32'd1000, 13'd0, 1'b1, 1'b0);
        wait_idle();

        // close it under a new ceiling, with one slot pulled up to the floor
        program_regs(13'd3000, 13'd1200);
        queue_slot(32'd1000, 13'd0, 1'b1, 1'b0);
        queue_slot(32'd10, 13'd0, 1'b1, 1'b1);
        wait_idle();

        // ceiling of zero, floor above the ceiling
        program_regs(13'd0, 13'd8191);
        queue_slot(32'd77, 13'd0, 1'b1, 1'b0);
        queue_slot(32'd3, 13'd500, 1'b1, 1'b0);
        queue_slot(32'd9, 13'd1, 1'b0, 1'b1);
        wait_idle();

        // floor equal to the top ceiling
        program_regs(13'd8191, 13'd8191);
        queue_slot(32'd100, 13'd50, 1'b1, 1'b0);
        queue_slot(32'd7, 13'd8191, 1'b1, 1'b1);
        wait_idle();

        // random sets, no idling, plus one set that closes by overflow
        program_random();
        queue_random_sets(8);
        queue_set(MAX_SLOTS, 1'b0);
        wait_idle();

        idle_mode = IDLE_SEND;
        program_regs(13'd8191, 13'd0);
        queue_random_sets(10);
        wait_idle();

        idle_mode = IDLE_RECV;
        program_random();
        queue_random_sets(10);
        wait_idle();

        idle_mode = IDLE_BOTH;
        program_random();
        queue_random_sets(10);
        wait_idle();

        // receiver holds off while two sets are offered back to back
        program_random();
        idle_mode = IDLE_HOLD;
        queue_set(6, 1'b1);
        queue_set(6, 1'b1);
        wait_idle();

        idle_mode = IDLE_BOTH;
        program_regs(CEIL_RESET, MHZ_W'($urandom_range(0, 8191)));
        queue_random_sets(8);
        wait_idle();

        $display("run covered %0d slot requests in %0d sets, %0d closed by overflow",
                 slots_accepted, sets_closed, overflow_sets);
        $display("%0d targets checked under %0d register settings and five idling patterns",
                 targets_checked, settings_used);
        if (err_count == 0 && planned_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
